// ===== rtl/tlbe_pkg.sv =====
package tlbe_pkg;

    // default fixed-point fraction width
    localparam int FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int COORD_W   = 18;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 3;
    localparam int NUM_BASIS = 6;

    // element order, as carried in the input tuser
    typedef enum logic [1:0] {
        MODE_P0  = 2'd0,
        MODE_P1  = 2'd1,
        MODE_P2  = 2'd2,
        MODE_BAD = 2'd3
    } t_mode;

    // last basis index of each order
    localparam logic [IDX_W-1:0] LAST_P0 = 3'd0;
    localparam logic [IDX_W-1:0] LAST_P1 = 3'd2;
    localparam logic [IDX_W-1:0] LAST_P2 = 3'd5;

    // operand pair of the shared multiplier
    typedef enum logic [1:0] {
        MUL_XX = 2'd0,
        MUL_XY = 2'd1,
        MUL_YY = 2'd2,
        MUL_NV = 2'd3
    } t_mul_sel;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MXX,
        ST_MXY,
        ST_MYY,
        ST_VAL,
        ST_PROD,
        ST_ACC,
        ST_BAD,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic             load_in;
        logic             mul_en;
        t_mul_sel         mul_sel;
        logic             val_en;
        logic             acc_en;
        logic             bad_en;
        t_mode            mode;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_cmd;

endpackage

// ===== rtl/triangle_lagrange_basis_eval.sv =====
// Sequence: after the input transfer, P2 first forms x*x, x*y and y*y; P0 and P1 go straight to the bases.
// Each basis result then passes through value, multiply, accumulate and output states, plus stall time.
// The single shared 32x32 multiplier serves every product; a new item is taken only once the last result
// of the previous item is accepted. An invalid order goes through ST_BAD to one result with bad_type set.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle, no output pending.
module triangle_lagrange_basis_eval import tlbe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // coord_x, coord_y, node_value_0 .. node_value_5, zero pad
    input  logic [231:0] i_s_tdata,
    // mode
    input  logic [1:0]   i_s_tuser,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // basis_index, basis_value, basis_grad_x, basis_grad_y, partial_sum, zero pad
    output logic [135:0] o_m_tdata,
    // bad_type
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast
);

    t_cmd cmd;

    // sequencer
    tlbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_mode     (t_mode'(i_s_tuser)),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // arithmetic
    tlbe_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_s_tdata (i_s_tdata),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

endmodule

// ===== rtl/tlbe_ctrl.sv =====
module tlbe_ctrl import tlbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_mode i_mode,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    t_mode            r_mode, n_mode;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] last_idx;
    logic             s_xfer;
    logic             m_xfer;
    logic             is_last;

    assign s_xfer = i_s_tvalid && (r_state == ST_IDLE);
    assign m_xfer = i_m_tready && (r_state == ST_OUT);

    // last basis index for the current order
    always_comb begin
        unique case (r_mode)
            MODE_P0: last_idx = LAST_P0;
            MODE_P1: last_idx = LAST_P1;
            MODE_P2: last_idx = LAST_P2;
            default: last_idx = LAST_P0;
        endcase
    end

    assign is_last = (r_idx == last_idx) || (r_mode == MODE_BAD);

    // next state
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_mode = i_mode;
                    n_idx  = '0;
                    unique case (i_mode)
                        MODE_P2:  n_state = ST_MXX;
                        MODE_BAD: n_state = ST_BAD;
                        default:  n_state = ST_VAL;
                    endcase
                end
            end
            ST_MXX:  n_state = ST_MXY;
            ST_MXY:  n_state = ST_MYY;
            ST_MYY:  n_state = ST_VAL;
            ST_VAL:  n_state = ST_PROD;
            ST_PROD: n_state = ST_ACC;
            ST_ACC:  n_state = ST_OUT;
            ST_BAD:  n_state = ST_OUT;
            ST_OUT: begin
                if (m_xfer) begin
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = ST_VAL;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_XX;
        o_cmd.mode    = r_mode;
        o_cmd.idx     = r_idx;
        o_cmd.last    = is_last;
        o_s_tready    = 1'b0;
        o_m_tvalid    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = s_xfer;
            end
            ST_MXX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_XX;
            end
            ST_MXY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_XY;
            end
            ST_MYY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_YY;
            end
            ST_VAL:  o_cmd.val_en = 1'b1;
            ST_PROD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NV;
            end
            ST_ACC:  o_cmd.acc_en = 1'b1;
            ST_BAD:  o_cmd.bad_en = 1'b1;
            ST_OUT:  o_m_tvalid   = 1'b1;
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_P0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== rtl/tlbe_dp.sv =====
module tlbe_dp import tlbe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  t_cmd         i_cmd,
    input  logic [231:0] i_s_tdata,
    output logic [135:0] o_m_tdata,
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast
);

    // working width for basis values before the final shift
    localparam int PW = 2 * COORD_W;
    localparam int AW = (FRAC_BITS > COORD_W - 1) ? 2 * FRAC_BITS : FRAC_BITS + COORD_W - 1;
    localparam int VW = ((AW > PW) ? AW : PW) + 5;
    localparam int SW = 2 * VAL_W + 1;

    localparam logic signed [VW-1:0] ONE_V = VW'(1) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] OO_V  = VW'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [VW-1:0] VMAX  = $signed({{(VW-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [VW-1:0] VMIN  = $signed({{(VW-31){1'b1}}, {31{1'b0}}});
    localparam logic signed [SW-1:0] SMAX  = $signed({{(SW-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [SW-1:0] SMIN  = $signed({{(SW-31){1'b1}}, {31{1'b0}}});

    function automatic logic signed [VAL_W-1:0] sat_v(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = v;
        if (t > VMAX) t = VMAX;
        if (t < VMIN) t = VMIN;
        return t[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_s(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v;
        if (t > SMAX) t = SMAX;
        if (t < SMIN) t = SMIN;
        return t[VAL_W-1:0];
    endfunction

    // item registers
    logic signed [COORD_W-1:0] r_x, r_y;
    logic signed [VAL_W-1:0]   r_nv [NUM_BASIS];
    logic signed [PW-1:0]      r_xx, r_xy, r_yy;
    logic signed [VAL_W-1:0]   r_val, r_gx, r_gy, r_acc;
    logic signed [2*VAL_W-1:0] r_prod;

    // result registers
    logic [IDX_W-1:0]        r_o_idx;
    logic signed [VAL_W-1:0] r_o_val, r_o_gx, r_o_gy, r_o_sum;
    logic                    r_o_last, r_o_bad;

    logic signed [VAL_W-1:0]   mul_a, mul_b;
    logic signed [2*VAL_W-1:0] mul_p;
    logic signed [VW-1:0]      ex, ey, xo, yo, exx, exy, eyy;
    logic signed [VW-1:0]      q, v_full, g_x, g_y;
    logic signed [2*VAL_W-1:0] prod_sh;
    logic signed [SW-1:0]      sum;

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_XX: begin
                mul_a = VAL_W'(r_x);
                mul_b = VAL_W'(r_x);
            end
            MUL_XY: begin
                mul_a = VAL_W'(r_x);
                mul_b = VAL_W'(r_y);
            end
            MUL_YY: begin
                mul_a = VAL_W'(r_y);
                mul_b = VAL_W'(r_y);
            end
            default: begin
                mul_a = r_val;
                mul_b = r_nv[i_cmd.idx];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign ex  = VW'(r_x);
    assign ey  = VW'(r_y);
    assign xo  = ex <<< FRAC_BITS;
    assign yo  = ey <<< FRAC_BITS;
    assign exx = VW'(r_xx);
    assign exy = VW'(r_xy);
    assign eyy = VW'(r_yy);

    // basis value and gradients for the current index
    always_comb begin
        q      = '0;
        v_full = '0;
        g_x    = '0;
        g_y    = '0;
        case (i_cmd.mode)
            MODE_P0: v_full = ONE_V;
            MODE_P1: begin
                case (i_cmd.idx)
                    3'd0: begin
                        v_full = ONE_V - ex - ey;
                        g_x    = -ONE_V;
                        g_y    = -ONE_V;
                    end
                    3'd1: begin
                        v_full = ex;
                        g_x    = ONE_V;
                    end
                    default: begin
                        v_full = ey;
                        g_y    = ONE_V;
                    end
                endcase
            end
            MODE_P2: begin
                case (i_cmd.idx)
                    3'd0: begin
                        q   = OO_V - 3 * xo - 3 * yo + 2 * exx + 2 * eyy + 4 * exy;
                        g_x = -3 * ONE_V + 4 * ex + 4 * ey;
                        g_y = -3 * ONE_V + 4 * ey + 4 * ex;
                    end
                    3'd1: begin
                        q   = 4 * xo - 4 * exx - 4 * exy;
                        g_x = 4 * ONE_V - 8 * ex - 4 * ey;
                        g_y = -4 * ex;
                    end
                    3'd2: begin
                        q   = 2 * exx - xo;
                        g_x = 4 * ex - ONE_V;
                    end
                    3'd3: begin
                        q   = 4 * exy;
                        g_x = 4 * ey;
                        g_y = 4 * ex;
                    end
                    3'd4: begin
                        q   = 2 * eyy - yo;
                        g_y = 4 * ey - ONE_V;
                    end
                    default: begin
                        q   = 4 * yo - 4 * eyy - 4 * exy;
                        g_x = -4 * ey;
                        g_y = 4 * ONE_V - 8 * ey - 4 * ex;
                    end
                endcase
                // arithmetic shift floors toward minus infinity
                v_full = q >>> FRAC_BITS;
            end
            default: ;
        endcase
    end

    // interpolation term and running sum
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign sum     = SW'(r_acc) + SW'(prod_sh);

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_s_tdata[17:0];
            r_y   <= i_s_tdata[35:18];
            for (int i = 0; i < NUM_BASIS; i++) begin
                r_nv[i] <= i_s_tdata[36 + VAL_W*i +: VAL_W];
            end
            r_acc <= '0;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_XX:  r_xx   <= mul_p[PW-1:0];
                MUL_XY:  r_xy   <= mul_p[PW-1:0];
                MUL_YY:  r_yy   <= mul_p[PW-1:0];
                default: r_prod <= mul_p;
            endcase
        end
        if (i_cmd.val_en) begin
            r_val <= sat_v(v_full);
            r_gx  <= sat_v(g_x);
            r_gy  <= sat_v(g_y);
        end
        if (i_cmd.acc_en) begin
            r_acc <= sat_s(sum);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            r_o_idx  <= i_cmd.idx;
            r_o_val  <= r_val;
            r_o_gx   <= r_gx;
            r_o_gy   <= r_gy;
            r_o_sum  <= sat_s(sum);
            r_o_last <= i_cmd.last;
            r_o_bad  <= 1'b0;
        end else if (i_cmd.bad_en) begin
            r_o_idx  <= '0;
            r_o_val  <= '0;
            r_o_gx   <= '0;
            r_o_gy   <= '0;
            r_o_sum  <= '0;
            r_o_last <= 1'b1;
            r_o_bad  <= 1'b1;
        end
    end

    assign o_m_tdata = {5'b0, r_o_sum, r_o_gy, r_o_gx, r_o_val, r_o_idx};
    assign o_m_tuser = r_o_bad;
    assign o_m_tlast = r_o_last;

endmodule
